// ----- rtl/mdca_pkg.sv -----
package mdca_pkg;

  // request kinds
  localparam logic [1:0] REQ_CAN    = 2'd0;
  localparam logic [1:0] REQ_SERIAL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // motor actions
  localparam logic [2:0] ACT_STOP     = 3'd0;
  localparam logic [2:0] ACT_FWD      = 3'd1;
  localparam logic [2:0] ACT_BACK     = 3'd2;
  localparam logic [2:0] ACT_LEFT     = 3'd3;
  localparam logic [2:0] ACT_RIGHT    = 3'd4;
  localparam logic [2:0] ACT_FWD_DIFF = 3'd5;
  localparam logic [2:0] ACT_BCK_DIFF = 3'd6;

  // command letters
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_P = 8'h50;

  // mode flag in a mode frame
  localparam logic [7:0] MODE_FLAG_AUTO = 8'd1;

  // configuration register indexes
  localparam logic [2:0] CFG_DUTY_CEIL     = 3'd0;
  localparam logic [2:0] CFG_MIN_DUTY      = 3'd1;
  localparam logic [2:0] CFG_LETTER_DUTY   = 3'd2;
  localparam logic [2:0] CFG_LINK_TIMEOUT  = 3'd3;
  localparam logic [2:0] CFG_SER_TIMEOUT   = 3'd4;
  localparam logic [2:0] CFG_MODE_ID       = 3'd5;
  localparam logic [2:0] CFG_LETTER_ID     = 3'd6;
  localparam logic [2:0] CFG_TILT_ID       = 3'd7;

  // configuration reset values
  localparam logic [15:0] RST_DUTY_CEIL     = 16'd1000;
  localparam logic [15:0] RST_MIN_DUTY      = 16'd300;
  localparam logic [15:0] RST_LETTER_DUTY   = 16'd700;
  localparam logic [31:0] RST_LINK_TIMEOUT  = 32'd1000;
  localparam logic [31:0] RST_SER_TIMEOUT   = 32'd5000;
  localparam logic [10:0] RST_MODE_ID       = 11'd256;
  localparam logic [10:0] RST_LETTER_ID     = 11'd272;
  localparam logic [10:0] RST_TILT_ID       = 11'd288;

  // tilt math, tenths of a degree
  localparam logic signed [15:0] DEADZONE_TENTHS = 16'sd50;
  localparam logic signed [15:0] MAX_TILT_TENTHS = 16'sd300;
  localparam int unsigned        TILT_FULL_SCALE = 600;
  // bias that makes the tilt product non-negative before the divide
  localparam int unsigned        BIAS_QUOT       = 131072;
  localparam logic [27:0]        PROD_BIAS       = 28'(TILT_FULL_SCALE * BIAS_QUOT);
  // exact floor(x / 75) for x below 2^25 as (x * RECIP_75) >> 32
  localparam logic [25:0]        RECIP_75        = 26'd57266231;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_CAN    = 2'd1,
    SRC_SERIAL = 2'd2,
    SRC_IMU    = 2'd3
  } src_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [10:0] frame_id;
    logic [7:0]  frame_byte0;
    logic [7:0]  frame_byte1;
    logic [7:0]  frame_byte2;
    logic [7:0]  frame_byte3;
    logic [7:0]  serial_byte;
  } in_word_t;

  typedef struct packed {
    logic        drive_mode_out;
    logic [2:0]  motor_action;
    logic [15:0] left_duty;
    logic [15:0] right_duty;
    logic        failsafe_stop;
  } out_word_t;

endpackage

// ----- rtl/manual_drive_command_arbiter.sv -----
// manual drive command arbiter
//
// in_word carries one event per word: a CAN frame, a serial character or a
// control tick, each with its millisecond time stamp. a word is taken at a
// rising edge with in_valid high and in_stall low. out_word carries the motor
// command (mode, action, left/right duty, failsafe flag) under out_valid /
// out_stall. mode frames, serial A and serial P each give one stop word, a tick
// in manual mode gives one command word, every other event only updates state.
// cfg_valid / cfg_ready writes one of eight registers selected by cfg_index;
// cfg_ready is always high and writes belong to idle periods.
//
// out_valid rises once the word has passed the input register and then one
// event pass into the output register.
// throughput is one word per cycle unless out_stall holds back the output
// register; the event logic and the state update close in a single pass,
// so back-to-back words see each other's effects. tilt products are stored
// at frame time and divided by 600 at tick time.
// while out_stall holds a full output register, the input register keeps
// one word and then raises in_stall. reset (rst_n low, synchronous) empties
// both registers, restores the register defaults and puts the drive in
// manual mode with letter S and no command source.
module manual_drive_command_arbiter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mdca_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mdca_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] duty_ceil_r;
  logic [15:0] min_duty_r;
  logic [15:0] letter_duty_r;
  logic [31:0] link_timeout_r;
  logic [31:0] ser_timeout_r;
  logic [10:0] mode_id_r;
  logic [10:0] letter_id_r;
  logic [10:0] tilt_id_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_ceil_r    <= mdca_pkg::RST_DUTY_CEIL;
      min_duty_r     <= mdca_pkg::RST_MIN_DUTY;
      letter_duty_r  <= mdca_pkg::RST_LETTER_DUTY;
      link_timeout_r <= mdca_pkg::RST_LINK_TIMEOUT;
      ser_timeout_r  <= mdca_pkg::RST_SER_TIMEOUT;
      mode_id_r      <= mdca_pkg::RST_MODE_ID;
      letter_id_r    <= mdca_pkg::RST_LETTER_ID;
      tilt_id_r      <= mdca_pkg::RST_TILT_ID;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mdca_pkg::CFG_DUTY_CEIL:    duty_ceil_r    <= cfg_data[15:0];
        mdca_pkg::CFG_MIN_DUTY:     min_duty_r     <= cfg_data[15:0];
        mdca_pkg::CFG_LETTER_DUTY:  letter_duty_r  <= cfg_data[15:0];
        mdca_pkg::CFG_LINK_TIMEOUT: link_timeout_r <= cfg_data;
        mdca_pkg::CFG_SER_TIMEOUT:  ser_timeout_r  <= cfg_data;
        mdca_pkg::CFG_MODE_ID:      mode_id_r      <= cfg_data[10:0];
        mdca_pkg::CFG_LETTER_ID:    letter_id_r    <= cfg_data[10:0];
        mdca_pkg::CFG_TILT_ID:      tilt_id_r      <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: input register -> event logic -> output register
  // ---------------------------------------------------------------------------
  mdca_pkg::in_word_t  in_q_r;
  logic                in_q_valid_r;
  mdca_pkg::out_word_t out_q_r;
  logic                out_valid_r;
  logic                process_en;
  logic                in_accept;
  logic                res_valid;
  mdca_pkg::out_word_t res_word;

  // the event stage fires when a word is held, unless a result is parked and stalled
  assign process_en = in_q_valid_r && !(out_valid_r && out_stall);
  assign in_stall   = in_q_valid_r && !process_en;
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_word   = out_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_q_valid_r <= 1'b1;
    end else if (process_en) begin
      in_q_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (process_en && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process_en && res_valid) begin
      out_q_r <= res_word;
    end
  end

  // ---------------------------------------------------------------------------
  // drive state
  // ---------------------------------------------------------------------------
  logic               drive_mode_r,   drive_mode_nxt;
  logic [7:0]         last_letter_r,  last_letter_nxt;
  mdca_pkg::src_t     cmd_src_r,      cmd_src_nxt;
  logic [31:0]        last_time_r,    last_time_nxt;
  logic               tilt_zero_r,    tilt_zero_nxt;
  logic               tilt_reverse_r, tilt_reverse_nxt;
  // tilt is kept as (k * (max - min)) plus the duty limits of that moment
  logic signed [27:0] tilt_prod_l_r,  tilt_prod_l_nxt;
  logic signed [27:0] tilt_prod_rt_r, tilt_prod_rt_nxt;
  logic [15:0]        tilt_min_r,     tilt_min_nxt;
  logic [15:0]        tilt_max_r,     tilt_max_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_mode_r   <= 1'b0;
      last_letter_r  <= mdca_pkg::CH_S;
      cmd_src_r      <= mdca_pkg::SRC_NONE;
      last_time_r    <= '0;
      tilt_zero_r    <= 1'b1;
      tilt_reverse_r <= 1'b0;
    end else if (process_en) begin
      drive_mode_r   <= drive_mode_nxt;
      last_letter_r  <= last_letter_nxt;
      cmd_src_r      <= cmd_src_nxt;
      last_time_r    <= last_time_nxt;
      tilt_zero_r    <= tilt_zero_nxt;
      tilt_reverse_r <= tilt_reverse_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (process_en) begin
      tilt_prod_l_r  <= tilt_prod_l_nxt;
      tilt_prod_rt_r <= tilt_prod_rt_nxt;
      tilt_min_r     <= tilt_min_nxt;
      tilt_max_r     <= tilt_max_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // tilt frame: roll/pitch -> differential products
  // ---------------------------------------------------------------------------
  logic signed [15:0] roll_s;
  logic signed [15:0] pitch_s;
  logic signed [9:0]  roll_c;
  logic signed [9:0]  pitch_c;
  logic signed [9:0]  pitch_neg;
  logic [8:0]         pitch_mag;
  logic signed [10:0] k_left;
  logic signed [10:0] k_right;
  logic signed [16:0] duty_span;
  logic signed [27:0] prod_left;
  logic signed [27:0] prod_right;
  logic               in_deadzone;

  assign roll_s  = {in_q_r.frame_byte0, in_q_r.frame_byte1};
  assign pitch_s = {in_q_r.frame_byte2, in_q_r.frame_byte3};

  always_comb begin
    priority if (roll_s > mdca_pkg::MAX_TILT_TENTHS) begin
      roll_c = mdca_pkg::MAX_TILT_TENTHS[9:0];
    end else if (roll_s < -mdca_pkg::MAX_TILT_TENTHS) begin
      roll_c = 10'(-mdca_pkg::MAX_TILT_TENTHS);
    end else begin
      roll_c = roll_s[9:0];
    end
    priority if (pitch_s > mdca_pkg::MAX_TILT_TENTHS) begin
      pitch_c = mdca_pkg::MAX_TILT_TENTHS[9:0];
    end else if (pitch_s < -mdca_pkg::MAX_TILT_TENTHS) begin
      pitch_c = 10'(-mdca_pkg::MAX_TILT_TENTHS);
    end else begin
      pitch_c = pitch_s[9:0];
    end
  end

  assign pitch_neg = -pitch_c;
  assign pitch_mag = pitch_c[9] ? pitch_neg[8:0] : pitch_c[8:0];

  // k = 2*|pitch| +/- roll, in [-300, 900]
  assign k_left    = $signed({1'b0, pitch_mag, 1'b0}) + $signed({roll_c[9], roll_c});
  assign k_right   = $signed({1'b0, pitch_mag, 1'b0}) - $signed({roll_c[9], roll_c});
  assign duty_span = $signed({1'b0, duty_ceil_r}) - $signed({1'b0, min_duty_r});
  assign prod_left  = k_left * duty_span;
  assign prod_right = k_right * duty_span;

  assign in_deadzone = (pitch_s > -mdca_pkg::DEADZONE_TENTHS) &&
                       (pitch_s <  mdca_pkg::DEADZONE_TENTHS) &&
                       (roll_s  > -mdca_pkg::DEADZONE_TENTHS) &&
                       (roll_s  <  mdca_pkg::DEADZONE_TENTHS);

  // ---------------------------------------------------------------------------
  // tick: stored product -> duty = clamp(min + floor(prod / 600), 0, max)
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] tilt_duty(input logic signed [27:0] prod,
                                            input logic [15:0]        lo,
                                            input logic [15:0]        hi);
    logic [27:0]        biased;
    logic [24:0]        eighth;
    logic [50:0]        mult;
    logic [17:0]        quot;
    logic signed [19:0] sum;
    biased = $unsigned(prod) + mdca_pkg::PROD_BIAS;
    eighth = biased[27:3];
    mult   = 51'(eighth) * 51'(mdca_pkg::RECIP_75);
    quot   = mult[49:32];
    sum    = $signed({2'b00, quot}) - 20'sd131072 + $signed({4'b0000, lo});
    priority if (sum < 20'sd0) begin
      tilt_duty = '0;
    end else if (sum > $signed({4'b0000, hi})) begin
      tilt_duty = hi;
    end else begin
      tilt_duty = sum[15:0];
    end
  endfunction

  logic [15:0] tick_left;
  logic [15:0] tick_right;
  logic [31:0] elapsed;
  logic        timed_out;

  assign tick_left  = tilt_duty(tilt_prod_l_r,  tilt_min_r, tilt_max_r);
  assign tick_right = tilt_duty(tilt_prod_rt_r, tilt_min_r, tilt_max_r);
  assign elapsed    = in_q_r.now_ms - last_time_r;

  always_comb begin
    unique case (cmd_src_r)
      mdca_pkg::SRC_CAN,
      mdca_pkg::SRC_IMU:    timed_out = elapsed > link_timeout_r;
      mdca_pkg::SRC_SERIAL: timed_out = elapsed > ser_timeout_r;
      default:              timed_out = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // event logic
  // ---------------------------------------------------------------------------
  logic [2:0]  res_action;
  logic [15:0] res_left;
  logic [15:0] res_right;
  logic        res_failsafe;

  always_comb begin
    drive_mode_nxt   = drive_mode_r;
    last_letter_nxt  = last_letter_r;
    cmd_src_nxt      = cmd_src_r;
    last_time_nxt    = last_time_r;
    tilt_zero_nxt    = tilt_zero_r;
    tilt_reverse_nxt = tilt_reverse_r;
    tilt_prod_l_nxt  = tilt_prod_l_r;
    tilt_prod_rt_nxt = tilt_prod_rt_r;
    tilt_min_nxt     = tilt_min_r;
    tilt_max_nxt     = tilt_max_r;
    res_valid        = 1'b0;
    res_action       = mdca_pkg::ACT_STOP;
    res_left         = '0;
    res_right        = '0;
    res_failsafe     = 1'b0;

    unique case (in_q_r.req_type)
      mdca_pkg::REQ_CAN: begin
        // mode wins over letter, letter over tilt on shared ids
        priority if (in_q_r.frame_id == mode_id_r) begin
          res_valid = 1'b1;
          if (in_q_r.frame_byte0 == mdca_pkg::MODE_FLAG_AUTO) begin
            drive_mode_nxt = 1'b1;
          end else begin
            drive_mode_nxt   = 1'b0;
            last_letter_nxt  = mdca_pkg::CH_S;
            cmd_src_nxt      = mdca_pkg::SRC_NONE;
            tilt_zero_nxt    = 1'b1;
            tilt_reverse_nxt = 1'b0;
          end
        end else if (in_q_r.frame_id == letter_id_r) begin
          last_letter_nxt = in_q_r.frame_byte0;
          last_time_nxt   = in_q_r.now_ms;
          cmd_src_nxt     = mdca_pkg::SRC_CAN;
        end else if (in_q_r.frame_id == tilt_id_r) begin
          last_time_nxt = in_q_r.now_ms;
          cmd_src_nxt   = mdca_pkg::SRC_IMU;
          if (in_deadzone) begin
            tilt_zero_nxt    = 1'b1;
            tilt_reverse_nxt = 1'b0;
          end else begin
            tilt_zero_nxt    = 1'b0;
            tilt_reverse_nxt = pitch_s[15];
            tilt_prod_l_nxt  = prod_left;
            tilt_prod_rt_nxt = prod_right;
            tilt_min_nxt     = min_duty_r;
            tilt_max_nxt     = duty_ceil_r;
          end
        end else begin
          // unknown id, ignored
        end
      end

      mdca_pkg::REQ_SERIAL: begin
        priority if (in_q_r.serial_byte == mdca_pkg::CH_A) begin
          res_valid      = 1'b1;
          drive_mode_nxt = 1'b1;
          if (cmd_src_r == mdca_pkg::SRC_SERIAL) begin
            last_time_nxt = in_q_r.now_ms;
          end
        end else if (in_q_r.serial_byte == mdca_pkg::CH_P) begin
          res_valid        = 1'b1;
          drive_mode_nxt   = 1'b0;
          last_letter_nxt  = mdca_pkg::CH_S;
          cmd_src_nxt      = mdca_pkg::SRC_NONE;
          tilt_zero_nxt    = 1'b1;
          tilt_reverse_nxt = 1'b0;
        end else if (in_q_r.serial_byte == mdca_pkg::CH_F ||
                     in_q_r.serial_byte == mdca_pkg::CH_B ||
                     in_q_r.serial_byte == mdca_pkg::CH_L ||
                     in_q_r.serial_byte == mdca_pkg::CH_R ||
                     in_q_r.serial_byte == mdca_pkg::CH_S) begin
          last_letter_nxt = in_q_r.serial_byte;
          last_time_nxt   = in_q_r.now_ms;
          cmd_src_nxt     = mdca_pkg::SRC_SERIAL;
        end else begin
          // other characters are dropped
        end
      end

      mdca_pkg::REQ_TICK: begin
        if (!drive_mode_r) begin
          res_valid = 1'b1;
          priority if (timed_out) begin
            res_failsafe = 1'b1;
          end else if (cmd_src_r == mdca_pkg::SRC_IMU) begin
            if (!tilt_zero_r && (tick_left != '0 || tick_right != '0)) begin
              res_action = tilt_reverse_r ? mdca_pkg::ACT_BCK_DIFF
                                          : mdca_pkg::ACT_FWD_DIFF;
              res_left   = tick_left;
              res_right  = tick_right;
            end
          end else begin
            unique case (last_letter_r)
              mdca_pkg::CH_F: res_action = mdca_pkg::ACT_FWD;
              mdca_pkg::CH_B: res_action = mdca_pkg::ACT_BACK;
              mdca_pkg::CH_L: res_action = mdca_pkg::ACT_LEFT;
              mdca_pkg::CH_R: res_action = mdca_pkg::ACT_RIGHT;
              default:        res_action = mdca_pkg::ACT_STOP;
            endcase
            if (res_action != mdca_pkg::ACT_STOP) begin
              res_left  = letter_duty_r;
              res_right = letter_duty_r;
            end
          end
        end
      end

      default: begin
        // unused request code, ignored
      end
    endcase
  end

  always_comb begin
    res_word.drive_mode_out = drive_mode_nxt;
    res_word.motor_action   = res_action;
    res_word.left_duty      = res_left;
    res_word.right_duty     = res_right;
    res_word.failsafe_stop  = res_failsafe;
  end

endmodule
